// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macro, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with a label and a message
`define RPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

// File: sv/rpr_pkg.sv
// ----------------------------------------------------------------------------
// rpr_pkg
// codes and result type of the replica protection registry
// ----------------------------------------------------------------------------
package rpr_pkg;

  typedef enum logic [2:0] {
    OP_DECLARE  = 3'd0,
    OP_ANNOUNCE = 3'd1,
    OP_TICK     = 3'd2,
    OP_SYNC_Q   = 3'd3,
    OP_THREAT_Q = 3'd4
  } op_t;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REANN  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_ANSWER = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_HELD = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [2:0] REG_DEFAULT = 3'd0;
  localparam logic [2:0] REG_STEP    = 3'd1;
  localparam logic [2:0] REG_MAX     = 3'd2;
  localparam logic [2:0] REG_PERIOD  = 3'd3;
  localparam logic [2:0] REG_OWN     = 3'd4;
  localparam logic [2:0] REG_ACT     = 3'd5;

  localparam logic [7:0] NOT_DISTRIBUTED = 8'hFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] key;
    logic [7:0]  threat;
    logic [4:0]  count;
    logic [7:0]  target;
    logic        exclude;
    logic        last;
  } res_t;

endpackage

// File: sv/replica_protection_registry_unit.sv
// ----------------------------------------------------------------------------
// replica_protection_registry_unit
// table of protected units keyed by a 64-bit tag, kept in one entry ram
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Every command except a status-only
// one walks the entry ram one entry per step: an empty entry passes S_RD and
// S_NXT, a valid entry that is not the one searched for S_RD, S_CHK and S_NXT,
// and an entry that is worked on (a key hit, every valid entry of a tick or
// threat query) S_RD, S_CHK, S_UPD, S_THR and S_ACT; the command then hands
// its last result to the output register in S_FIN and returns to idle. The
// walk is paced by the single read port of the entry ram.
// A tick holds while a reannounce beat cannot enter the output register.
module replica_protection_registry_unit #(
  parameter int TABLE_ENTRIES = 16,
  parameter int NODE_COUNT    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // unit_key, wanted_replicas, holds_block, peer_node, region_peers,
  // tick_ms, zero fill
  input  logic [111:0] s_axis_tdata,
  // op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, out_key, threat, replica_count, target_replicas, exclude
  output logic [87:0]  m_axis_tdata,
  // kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int IDX_W = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NB_W  = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [63:0]           key;
    logic [7:0]            req;
    logic [7:0]            tgt;
    logic                  driven;
    logic [NODE_COUNT-1:0] bits;
    logic [CNT_W-1:0]      cnt;
    logic [31:0]           age;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);
  localparam entry_t ENTRY_ZERO = '0;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_CHK  = 8'b0000_0100,
    S_UPD  = 8'b0000_1000,
    S_THR  = 8'b0001_0000,
    S_ACT  = 8'b0010_0000,
    S_NXT  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [7:0]  default_replicas, threat_step, threat_max, own_node;
  logic [31:0] reannounce_period;
  logic        drive_enable;

  logic [2:0]  op;
  logic [63:0] key;
  logic [7:0]  want, peer, region;
  logic [15:0] elapsed;

  logic [IDX_W-1:0]         idx, free_idx;
  logic                     free_ok, ign;
  logic [TABLE_ENTRIES-1:0] valid;
  entry_t                   e;
  logic [7:0]               thr, worst;
  rpr_pkg::res_t            res, m_res;
  logic                     m_valid;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_q;
  logic [ENT_W-1:0] ram_rdata;

  logic        out_free, idx_last, hit, peer_bad;
  logic [7:0]  cap;
  logic [31:0] age_sum;

  entry_t      chk_e, upd_e, act_wdata;
  logic        upd_ign, drive_now, act_we, m_load;

  function automatic logic [7:0] cap_target(input logic [7:0] w, input logic [7:0] rg,
                                            input logic [7:0] dflt);
    logic [7:0] most;
    logic [7:0] v;
    most = (rg > 8'd1) ? rg - 8'd1 : 8'd1;
    v = (w == 8'd0) ? dflt : w;
    if (v > most) v = most;
    if (v < 8'd1) v = 8'd1;
    return v;
  endfunction

  function automatic logic [7:0] threat_of(input logic [CNT_W-1:0] have,
                                           input logic [7:0] tgt,
                                           input logic [7:0] step,
                                           input logic [7:0] tmax);
    logic [7:0]  h;
    logic [15:0] p;
    h = 8'(have);
    if (tgt == 8'd0 || h >= tgt) return 8'd0;
    p = 16'(tgt - h) * 16'(step);
    if (p > 16'(tmax)) return tmax;
    return p[7:0];
  endfunction

  function automatic rpr_pkg::res_t mk_res(input logic [1:0] kind, input logic [1:0] st,
                                           input logic [63:0] k, input logic use_e,
                                           input entry_t en, input logic [7:0] t,
                                           input logic excl, input logic lst);
    rpr_pkg::res_t r;
    r = '0;
    r.kind    = kind;
    r.status  = st;
    r.key     = k;
    r.exclude = excl;
    r.last    = lst;
    if (use_e) begin
      r.threat = t;
      r.count  = 5'(en.cnt);
      r.target = en.tgt;
    end
    return r;
  endfunction

  rpr_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign ram_q     = entry_t'(ram_rdata);
  assign out_free  = !m_valid || m_axis_tready;
  assign idx_last  = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign hit       = (ram_q.key == key);
  assign peer_bad  = (peer >= 8'(NODE_COUNT)) || (peer == own_node);
  assign cap       = cap_target(e.req, region, default_replicas);
  assign age_sum   = e.age + 32'(elapsed);
  assign drive_now = (thr != 8'd0) && drive_enable && (age_sum >= reannounce_period);
  assign m_load    = out_free && ((state == S_FIN) ||
                     (state == S_ACT && op == rpr_pkg::OP_TICK && drive_now));

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = m_res.kind;
  assign m_axis_tlast  = m_res.last;
  assign m_axis_tdata  = {m_res.exclude, m_res.target, m_res.count, m_res.threat,
                          m_res.key, m_res.status};

  // entry as read, with a raised request on declare
  always_comb begin
    chk_e = ram_q;
    if (op == rpr_pkg::OP_DECLARE && want > ram_q.req) chk_e.req = want;
  end

  // per-op entry update
  always_comb begin
    upd_e   = e;
    upd_ign = 1'b0;
    case (op)
      rpr_pkg::OP_DECLARE: upd_e.tgt = cap;
      rpr_pkg::OP_TICK: begin
        if (cap > e.tgt) upd_e.tgt = cap;
      end
      rpr_pkg::OP_ANNOUNCE: begin
        if (peer_bad || e.bits[peer[NB_W-1:0]]) begin
          upd_ign = 1'b1;
        end else begin
          upd_e.bits[peer[NB_W-1:0]] = 1'b1;
          if (e.cnt < CNT_W'(NODE_COUNT)) upd_e.cnt = e.cnt + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // write back of the worked entry
  always_comb begin
    act_wdata = e;
    act_we    = 1'b0;
    if (state == S_ACT) begin
      case (op)
        rpr_pkg::OP_DECLARE:  act_we = 1'b1;
        rpr_pkg::OP_ANNOUNCE: act_we = !ign;
        rpr_pkg::OP_TICK: begin
          if (drive_now) begin
            act_we           = out_free;
            act_wdata.age    = 32'd0;
            act_wdata.driven = 1'b1;
          end else begin
            act_we = 1'b1;
            if (thr != 8'd0 && drive_enable) act_wdata.age = age_sum;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (m_load) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      valid             <= '0;
      ram_we            <= 1'b0;
      default_replicas  <= 8'd3;
      threat_step       <= 8'd50;
      threat_max        <= 8'd200;
      reannounce_period <= 32'd1000;
      own_node          <= 8'd255;
      drive_enable      <= 1'b1;
    end else begin
      ram_we <= act_we;

      if (cfg_valid) begin
        case (cfg_addr)
          rpr_pkg::REG_DEFAULT: default_replicas  <= cfg_data[7:0];
          rpr_pkg::REG_STEP:    threat_step       <= cfg_data[7:0];
          rpr_pkg::REG_MAX:     threat_max        <= cfg_data[7:0];
          rpr_pkg::REG_PERIOD:  reannounce_period <= cfg_data;
          rpr_pkg::REG_OWN:     own_node          <= cfg_data[7:0];
          rpr_pkg::REG_ACT:     drive_enable      <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op      <= s_axis_tuser;
            key     <= s_axis_tdata[63:0];
            want    <= (s_axis_tdata[71:64] == 8'd0) ? default_replicas
                                                      : s_axis_tdata[71:64];
            peer    <= s_axis_tdata[80:73];
            region  <= s_axis_tdata[88:81];
            elapsed <= s_axis_tdata[104:89];
            idx     <= '0;
            free_ok <= 1'b0;
            worst   <= 8'd0;
            if (s_axis_tuser == rpr_pkg::OP_DECLARE && !s_axis_tdata[72]) begin
              res   <= mk_res(rpr_pkg::KIND_STATUS, rpr_pkg::ST_NOT_HELD,
                              s_axis_tdata[63:0], 1'b0, e, thr, 1'b0, 1'b1);
              state <= S_FIN;
            end else if (s_axis_tuser > rpr_pkg::OP_THREAT_Q) begin
              res   <= mk_res(rpr_pkg::KIND_STATUS, rpr_pkg::ST_IGNORED,
                              s_axis_tdata[63:0], 1'b0, e, thr, 1'b0, 1'b1);
              state <= S_FIN;
            end else if (s_axis_tuser == rpr_pkg::OP_TICK &&
                         own_node == rpr_pkg::NOT_DISTRIBUTED) begin
              res   <= mk_res(rpr_pkg::KIND_TICK, rpr_pkg::ST_OK, 64'd0, 1'b0, e, thr,
                              1'b0, 1'b1);
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (valid[idx]) begin
            state <= S_CHK;
          end else begin
            if (op == rpr_pkg::OP_DECLARE && !free_ok) begin
              free_idx <= idx;
              free_ok  <= 1'b1;
            end
            state <= S_NXT;
          end
        end
        S_CHK: begin
          e <= chk_e;
          if (op == rpr_pkg::OP_TICK || op == rpr_pkg::OP_THREAT_Q || hit) begin
            state <= S_UPD;
          end else begin
            state <= S_NXT;
          end
        end
        S_UPD: begin
          e     <= upd_e;
          ign   <= upd_ign;
          state <= S_THR;
        end
        S_THR: begin
          thr   <= threat_of(e.cnt, e.tgt, threat_step, threat_max);
          state <= S_ACT;
        end
        S_ACT: begin
          ram_waddr <= idx;
          ram_wdata <= act_wdata;
          case (op)
            rpr_pkg::OP_DECLARE: begin
              valid[idx] <= 1'b1;
              res   <= mk_res(rpr_pkg::KIND_STATUS, rpr_pkg::ST_OK, key, 1'b1, e, thr,
                              1'b0, 1'b1);
              state <= S_FIN;
            end
            rpr_pkg::OP_ANNOUNCE: begin
              res   <= mk_res(rpr_pkg::KIND_STATUS,
                              ign ? rpr_pkg::ST_IGNORED : rpr_pkg::ST_OK,
                              key, 1'b1, e, thr, 1'b0, 1'b1);
              state <= S_FIN;
            end
            rpr_pkg::OP_SYNC_Q: begin
              res   <= mk_res(rpr_pkg::KIND_ANSWER, rpr_pkg::ST_OK, key, 1'b1, e, thr,
                              !e.driven, 1'b1);
              state <= S_FIN;
            end
            rpr_pkg::OP_THREAT_Q: begin
              if (thr > worst) worst <= thr;
              state <= S_NXT;
            end
            rpr_pkg::OP_TICK: begin
              if (!drive_now) begin
                state <= S_NXT;
              end else if (m_load) begin
                m_res <= mk_res(rpr_pkg::KIND_REANN, rpr_pkg::ST_OK, e.key, 1'b1,
                                e, thr, 1'b0, 1'b0);
                state <= S_NXT;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_NXT: begin
          if (!idx_last) begin
            idx   <= idx + IDX_W'(1);
            state <= S_RD;
          end else begin
            state <= S_FIN;
            case (op)
              rpr_pkg::OP_DECLARE: begin
                if (free_ok) begin
                  e     <= '{key: key, req: want, tgt: 8'd0, driven: 1'b0, bits: '0,
                             cnt: '0, age: reannounce_period};
                  idx   <= free_idx;
                  state <= S_UPD;
                end else begin
                  res <= mk_res(rpr_pkg::KIND_STATUS, rpr_pkg::ST_FULL, key, 1'b0, e,
                                thr, 1'b0, 1'b1);
                end
              end
              rpr_pkg::OP_ANNOUNCE:
                res <= mk_res(rpr_pkg::KIND_STATUS, rpr_pkg::ST_IGNORED, key, 1'b0, e,
                              thr, 1'b0, 1'b1);
              rpr_pkg::OP_SYNC_Q:
                res <= mk_res(rpr_pkg::KIND_ANSWER, rpr_pkg::ST_OK, key, 1'b0, e, thr,
                              1'b0, 1'b1);
              rpr_pkg::OP_THREAT_Q:
                res <= mk_res(rpr_pkg::KIND_ANSWER, rpr_pkg::ST_OK, 64'd0, 1'b1,
                              ENTRY_ZERO, worst, 1'b0, 1'b1);
              default:
                res <= mk_res(rpr_pkg::KIND_TICK, rpr_pkg::ST_OK, 64'd0, 1'b0, e, thr,
                              1'b0, 1'b1);
            endcase
          end
        end
        S_FIN: begin
          if (m_load) begin
            m_res <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/rpr_ram.sv
// ----------------------------------------------------------------------------
// rpr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rpr_checker.sv
// ----------------------------------------------------------------------------
// rpr_checker
// port-level checks of the replica protection registry
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  `RPR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `RPR_ASSERT(a_one_cmd, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "command taken while busy")
  `RPR_ASSERT(a_reann_not_last, m_axis_tvalid && m_axis_tuser == rpr_pkg::KIND_REANN |-> !m_axis_tlast, "reannounce beat marked last")
  `RPR_ASSERT(a_other_last, m_axis_tvalid && m_axis_tuser != rpr_pkg::KIND_REANN |-> m_axis_tlast, "final beat not marked last")
  `RPR_ASSERT(a_tick_nokey, m_axis_tvalid && m_axis_tuser == rpr_pkg::KIND_TICK |-> m_axis_tdata[65:2] == 64'd0, "tick beat carries a key")

endmodule

bind replica_protection_registry_unit rpr_checker u_rpr_checker (.*);
